[src/assert_macros.svh]
// Assertion macros used by the page allocator datapath.
// Each macro checks on the rising clock edge and is quiet while the active-low reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge
`define CHK_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant check failed");

// Antecedent implies consequent in the same cycle
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

[src/trpfs_pkg.sv]
// Shared types, constants and controller/datapath interface structs for the
// two-region page free stack. No dependencies.
`default_nettype none

package trpfs_pkg;

	// Geometry
	localparam int ADDR_W           = 56;
	localparam int PAGE_SHIFT       = 12;
	localparam int MAX_REGION_PAGES = 4096;
	localparam int PN_W             = ADDR_W - PAGE_SHIFT;
	localparam int IDX_W            = $clog2(MAX_REGION_PAGES);
	localparam int CNT_W            = IDX_W + 1;
	localparam int RAM_AW           = IDX_W + 1;
	localparam int RAM_DEPTH        = 2 * MAX_REGION_PAGES;

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [ADDR_W:0]       addr_x_t;
	typedef logic [PN_W-1:0]       pn_t;
	typedef logic [PN_W:0]         pn_x_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [CNT_W:0]        cnt_x_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [PAGE_SHIFT-1:0] ofs_t;
	typedef logic [RAM_AW-1:0]     ram_addr_t;
	typedef logic [1:0]            req_t;
	typedef logic [2:0]            st_t;
	typedef logic [1:0]            cfg_idx_t;

	// Request codes
	localparam req_t REQ_ALLOC   = 2'd0;
	localparam req_t REQ_FREE    = 2'd1;
	localparam req_t REQ_REBUILD = 2'd2;

	// Status codes
	localparam st_t ST_OK    = 3'd0;
	localparam st_t ST_OOM   = 3'd1;
	localparam st_t ST_ALIGN = 3'd2;
	localparam st_t ST_RANGE = 3'd3;
	localparam st_t ST_OVER  = 3'd4;

	// Configuration register indexes
	localparam cfg_idx_t CFG_BEGIN = 2'd0;
	localparam cfg_idx_t CFG_END   = 2'd1;
	localparam cfg_idx_t CFG_QUOTA = 2'd2;

	localparam cnt_t QUOTA_RESET = cnt_t'(1024);
	localparam cnt_t MAX_PAGES   = cnt_t'(MAX_REGION_PAGES);
	localparam cnt_t CNT_SAT     = '1;
	localparam addr_t OFS_ROUND  = addr_t'((64'd1 << PAGE_SHIFT) - 64'd1);

	// Per-region bookkeeping
	typedef struct packed {
		cnt_t freed;
		cnt_t untouched;
		pn_t  first;
		pn_t  limit;
	} region_t;

	// Controller to datapath
	typedef struct packed {
		logic cap;
		logic exec;
		logic reb_first;
		logic reb_total;
		logic reb_kern;
		logic reb_user;
		logic reb_apply;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic new_rebuild;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

[src/trpfs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module trpfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/trpfs_ctrl.sv]
// Request sequencer for the page free stack: accepts a request, steps the
// rebuild sequence and triggers execution. Depends on trpfs_pkg.
`default_nettype none

module trpfs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire trpfs_pkg::dp_stat_t st,
	output trpfs_pkg::dp_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_RFIRST = 3'd2;
	localparam logic [2:0] S_RTOTAL = 3'd3;
	localparam logic [2:0] S_RKERN  = 3'd4;
	localparam logic [2:0] S_RUSER  = 3'd5;
	localparam logic [2:0] S_RAPPLY = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = st.new_rebuild ? S_RFIRST : S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_RFIRST: begin
				cmd.reb_first = 1'b1;
				state_d       = S_RTOTAL;
			end
			S_RTOTAL: begin
				cmd.reb_total = 1'b1;
				state_d       = S_RKERN;
			end
			S_RKERN: begin
				cmd.reb_kern = 1'b1;
				state_d      = S_RUSER;
			end
			S_RUSER: begin
				cmd.reb_user = 1'b1;
				state_d      = S_RAPPLY;
			end
			S_RAPPLY: begin
				cmd.reb_apply = 1'b1;
				state_d       = S_EXEC;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[src/trpfs_dp.sv]
// Datapath of the page free stack: configuration, region registers, freed-page
// RAM, rebuild arithmetic and result register. Depends on trpfs_pkg, trpfs_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module trpfs_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire trpfs_pkg::cfg_idx_t        cfg_index,
	input  wire trpfs_pkg::addr_t           cfg_wdata,
	input  wire trpfs_pkg::req_t            req_type,
	input  wire logic                       kern_sel,
	input  wire trpfs_pkg::addr_t           page_addr,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output trpfs_pkg::addr_t                alloc_addr,
	output trpfs_pkg::st_t                  status,
	output trpfs_pkg::cnt_t                 free_pages,
	input  wire trpfs_pkg::dp_cmd_t         cmd,
	output trpfs_pkg::dp_stat_t             st
);

	// Configuration registers
	trpfs_pkg::addr_t alloc_begin_q;
	trpfs_pkg::addr_t alloc_end_q;
	trpfs_pkg::cnt_t  quota_q;

	// Region state
	trpfs_pkg::region_t kreg_q;
	trpfs_pkg::region_t ureg_q;

	// Captured request
	trpfs_pkg::req_t  req_q;
	logic             sel_kern_q;
	trpfs_pkg::addr_t page_addr_q;

	// Rebuild pipeline
	trpfs_pkg::pn_x_t first_s1;
	trpfs_pkg::pn_t   last_s1;
	trpfs_pkg::pn_t   total_s2;
	trpfs_pkg::cnt_t  kp_s3;
	trpfs_pkg::cnt_t  up_s4;
	trpfs_pkg::pn_x_t mid_s4;

	// Result register
	logic             out_valid_q;
	trpfs_pkg::addr_t alloc_addr_q;
	trpfs_pkg::st_t   status_q;
	trpfs_pkg::cnt_t  free_pages_q;

	// Freed-page RAM signals
	logic                 ram_we;
	trpfs_pkg::ram_addr_t ram_waddr;
	trpfs_pkg::ram_addr_t ram_raddr;
	trpfs_pkg::pn_t       ram_rdata;

	// Execute-stage signals
	trpfs_pkg::region_t sel;
	trpfs_pkg::region_t nxt;
	trpfs_pkg::addr_t   res_addr;
	trpfs_pkg::st_t     res_st;
	logic               push;
	trpfs_pkg::cnt_t    dec_untouched;
	trpfs_pkg::pn_t     free_pn;
	trpfs_pkg::cnt_x_t  cnt_sum;
	trpfs_pkg::cnt_t    res_cnt;
	trpfs_pkg::cnt_t    rd_freed;
	logic               out_free;

	// Rebuild-step signals
	trpfs_pkg::addr_x_t begin_sum;
	trpfs_pkg::cnt_t    kp_a;
	trpfs_pkg::pn_t     rest;

	assign out_free = !out_valid_q || !out_stall;
	assign st       = trpfs_pkg::dp_stat_t'{
		new_rebuild: (req_type == trpfs_pkg::REQ_REBUILD),
		out_free:    out_free
	};

	// Configuration writes; unlisted indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_begin_q <= '0;
			alloc_end_q   <= '0;
			quota_q       <= trpfs_pkg::QUOTA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				trpfs_pkg::CFG_BEGIN: alloc_begin_q <= cfg_wdata;
				trpfs_pkg::CFG_END:   alloc_end_q   <= cfg_wdata;
				trpfs_pkg::CFG_QUOTA: quota_q       <= cfg_wdata[trpfs_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the request at transfer
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q       <= req_type;
			sel_kern_q  <= kern_sel;
			page_addr_q <= page_addr;
		end
	end

	// Speculative read of the top of stack for a possible pop
	assign rd_freed  = (kern_sel ? kreg_q.freed : ureg_q.freed) - 1'b1;
	assign ram_raddr = {kern_sel, rd_freed[trpfs_pkg::IDX_W-1:0]};

	// Push address for a free
	assign ram_waddr = {sel_kern_q, sel.freed[trpfs_pkg::IDX_W-1:0]};
	assign ram_we    = cmd.exec && push;

	trpfs_ram #(
		.WIDTH(trpfs_pkg::PN_W),
		.DEPTH(trpfs_pkg::RAM_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (free_pn),
		.re    (cmd.cap),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Execute: alloc pop / untouched take, free push with checks
	assign sel           = sel_kern_q ? kreg_q : ureg_q;
	assign dec_untouched = sel.untouched - 1'b1;
	assign free_pn       = page_addr_q[trpfs_pkg::ADDR_W-1:trpfs_pkg::PAGE_SHIFT];

	always_comb begin
		nxt      = sel;
		res_addr = '0;
		res_st   = trpfs_pkg::ST_OK;
		push     = 1'b0;
		unique case (req_q)
			trpfs_pkg::REQ_ALLOC: begin
				if (sel.freed != '0) begin
					nxt.freed = sel.freed - 1'b1;
					res_addr  = {ram_rdata, {trpfs_pkg::PAGE_SHIFT{1'b0}}};
				end else if (sel.untouched != '0) begin
					nxt.untouched = dec_untouched;
					res_addr      = {sel.first + trpfs_pkg::pn_t'(dec_untouched),
						{trpfs_pkg::PAGE_SHIFT{1'b0}}};
				end else begin
					res_st = trpfs_pkg::ST_OOM;
				end
			end
			trpfs_pkg::REQ_FREE: begin
				if (page_addr_q[trpfs_pkg::PAGE_SHIFT-1:0] != '0) begin
					res_st = trpfs_pkg::ST_ALIGN;
				end else if (free_pn < sel.first || free_pn >= sel.limit) begin
					res_st = trpfs_pkg::ST_RANGE;
				end else if (sel.freed >= trpfs_pkg::MAX_PAGES) begin
					res_st = trpfs_pkg::ST_OVER;
				end else begin
					push      = 1'b1;
					nxt.freed = sel.freed + 1'b1;
				end
			end
			default: ;
		endcase
		cnt_sum = {1'b0, nxt.freed} + {1'b0, nxt.untouched};
		res_cnt = (cnt_sum > {1'b0, trpfs_pkg::CNT_SAT}) ? trpfs_pkg::CNT_SAT
			: cnt_sum[trpfs_pkg::CNT_W-1:0];
	end

	// Rebuild step arithmetic
	assign begin_sum = {1'b0, alloc_begin_q} + {1'b0, trpfs_pkg::OFS_ROUND};

	always_comb begin
		if (trpfs_pkg::pn_t'(quota_q) > total_s2) begin
			kp_a = total_s2[trpfs_pkg::CNT_W-1:0];
		end else begin
			kp_a = quota_q;
		end
		if (kp_a > trpfs_pkg::MAX_PAGES) begin
			kp_a = trpfs_pkg::MAX_PAGES;
		end
	end

	assign rest = total_s2 - trpfs_pkg::pn_t'(kp_s3);

	// Rebuild pipeline registers
	always_ff @(posedge clk) begin
		if (cmd.reb_first) begin
			first_s1 <= begin_sum[trpfs_pkg::ADDR_W:trpfs_pkg::PAGE_SHIFT];
			last_s1  <= alloc_end_q[trpfs_pkg::ADDR_W-1:trpfs_pkg::PAGE_SHIFT];
		end
		if (cmd.reb_total) begin
			total_s2 <= ({1'b0, last_s1} > first_s1) ? last_s1 - first_s1[trpfs_pkg::PN_W-1:0]
				: '0;
		end
		if (cmd.reb_kern) begin
			kp_s3 <= kp_a;
		end
		if (cmd.reb_user) begin
			up_s4  <= (rest > trpfs_pkg::pn_t'(trpfs_pkg::MAX_PAGES)) ? trpfs_pkg::MAX_PAGES
				: rest[trpfs_pkg::CNT_W-1:0];
			mid_s4 <= first_s1 + trpfs_pkg::pn_x_t'(kp_s3);
		end
	end

	// Region registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kreg_q <= '0;
			ureg_q <= '0;
		end else if (cmd.reb_apply) begin
			kreg_q.first     <= first_s1[trpfs_pkg::PN_W-1:0];
			kreg_q.limit     <= mid_s4[trpfs_pkg::PN_W-1:0];
			kreg_q.freed     <= '0;
			kreg_q.untouched <= kp_s3;
			ureg_q.first     <= mid_s4[trpfs_pkg::PN_W-1:0];
			ureg_q.limit     <= mid_s4[trpfs_pkg::PN_W-1:0] + trpfs_pkg::pn_t'(up_s4);
			ureg_q.freed     <= '0;
			ureg_q.untouched <= up_s4;
		end else if (cmd.exec) begin
			if (sel_kern_q) begin
				kreg_q <= nxt;
			end else begin
				ureg_q <= nxt;
			end
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			alloc_addr_q <= res_addr;
			status_q     <= res_st;
			free_pages_q <= res_cnt;
		end
	end

	assign out_valid  = out_valid_q;
	assign alloc_addr = alloc_addr_q;
	assign status     = status_q;
	assign free_pages = free_pages_q;

	// Checks
	`CHK_IMPLY(a_exec_has_room, clk, arst_n, cmd.exec, out_free)
	`CHK_NEXT(a_exec_shows_result, clk, arst_n, cmd.exec, out_valid_q)
	`CHK_ALWAYS(a_kern_bounds, clk, arst_n, kreg_q.first <= kreg_q.limit)
	`CHK_ALWAYS(a_user_bounds, clk, arst_n, ureg_q.first <= ureg_q.limit)
	`CHK_IMPLY(a_addr_means_ok, clk, arst_n, out_valid_q && alloc_addr_q != '0, status_q == trpfs_pkg::ST_OK)

endmodule

`default_nettype wire

[src/two_region_page_free_stack_core.sv]
// Two-region LIFO page allocator: alloc, free and rebuild, one request at a time.
// Alloc, free and unused codes pass through transfer, then execute with the stack RAM read.
// Rebuild passes through transfer, five rebuild arithmetic steps, then execute.
// The result appears on the cycle after execute; the next request is taken meanwhile.
// Execute waits while a previous result is held by out_stall.
// Asynchronous reset empties both regions and sets quota 1024; the stack RAM is not cleared.
`default_nettype none

module two_region_page_free_stack_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire trpfs_pkg::cfg_idx_t cfg_index,
	input  wire trpfs_pkg::addr_t    cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire trpfs_pkg::req_t     req_type,
	input  wire logic                kern_sel,
	input  wire trpfs_pkg::addr_t    page_addr,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output trpfs_pkg::addr_t         alloc_addr,
	output trpfs_pkg::st_t           status,
	output trpfs_pkg::cnt_t          free_pages
);

	trpfs_pkg::dp_cmd_t  cmd;
	trpfs_pkg::dp_stat_t st;

	trpfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	trpfs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req_type),
		.kern_sel   (kern_sel),
		.page_addr  (page_addr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.alloc_addr (alloc_addr),
		.status     (status),
		.free_pages (free_pages),
		.cmd        (cmd),
		.st         (st)
	);

endmodule

`default_nettype wire
